// ----- hw/rtl/jdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdc_pkg: shared types and constants of the Julian day converter
// Payload structs for the request and result transfers, calendar limits and
// the cumulative month-length table used by both conversion directions.
// ----------------------------------------------------------------------------
package jdc_pkg;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int JD_W    = 23;
  localparam int WDAY_W  = 3;

  // supported range
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [JD_W-1:0]    JD_MIN    = 23'd1721426;
  localparam logic [JD_W-1:0]    JD_MAX    = 23'd5373484;

  // division by 100 through a reciprocal with one correction step
  localparam int unsigned CENT    = 100;
  localparam int unsigned RCP_100 = (1 << 14) / CENT;

  // floor(367 * k / 12), also floor(2447 * k / 80) for k up to 13
  localparam logic [8:0] CUM_DAYS [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
  };

  // conversion direction
  typedef enum logic {
    FUNC_DATE_TO_JD = 1'b0,
    FUNC_JD_TO_DATE = 1'b1
  } func_t;

  // request payload
  typedef struct packed {
    func_t              func;
    logic [YEAR_W-1:0]  year_in;
    logic [MONTH_W-1:0] month_in;
    logic [DAY_W-1:0]   day_in;
    logic [JD_W-1:0]    julian_in;
  } jdc_in_t;

  // result payload
  typedef struct packed {
    logic [JD_W-1:0]    julian_out;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;
    logic [WDAY_W-1:0]  weekday;
    logic               leap_year;
    logic               range_error;
  } jdc_out_t;

endpackage

// ----- hw/rtl/julian_day_date_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_day_date_converter: Gregorian date <-> Julian day number
// Fliegel-Van Flandern conversion in both directions with weekday and
// leap-year flag, fully pipelined.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge with start high; busy never rises,
// so one conversion enters per cycle with no gaps. Each result appears on
// rsp with done high for one cycle, in request order. The pipeline depth
// is set by the Julian-day-to-date chain: twelve stages holding three
// constant divisions, each a reciprocal multiply stage followed by a
// correction stage, plus two stages for the weekday and leap flags. done
// cannot be held off, so the receiver must take every result as it comes.
module julian_day_date_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  jdc_pkg::jdc_in_t  req,
  output logic              done,
  output jdc_pkg::jdc_out_t rsp
);
  import jdc_pkg::*;

  // algorithm constants
  localparam int unsigned OFS_JD      = 68569;
  localparam int unsigned DAYS_400Y   = 146097;
  localparam int unsigned DAYS_4000Y  = 1461001;
  localparam int unsigned DAYS_4Y     = 1461;
  localparam int unsigned MONTH_DIV   = 2447;
  localparam int unsigned MONTH_SCALE = 80;
  localparam int unsigned YEAR_SCALE  = 4000;
  localparam int unsigned JD_BIAS     = 32075;
  localparam int unsigned EPOCH_Y     = 4800;
  localparam int unsigned MONTH_BIAS  = 31;
  localparam int unsigned RCP_400Y    = (1 << 25) / DAYS_400Y;
  localparam int unsigned RCP_4000Y   = (1 << 28) / DAYS_4000Y;
  localparam int unsigned RCP_MONTH   = (1 << 17) / MONTH_DIV;
  localparam int          LAT         = 14;

  typedef struct packed {
    func_t              func;
    logic               err;
    logic [YEAR_W-1:0]  yi;
    logic [MONTH_W-1:0] mi;
    logic [DAY_W-1:0]   di;
    logic [JD_W-1:0]    jd;
    // date to julian
    logic [14:0]        a;
    logic [8:0]         mterm;
    logic [22:0]        t1;
    logic [13:0]        ap;
    logic [7:0]         c;
    logic [22:0]        base;
    // julian to date
    logic [22:0]        p;
    logic [24:0]        x;
    logic [7:0]         q;
    logic [15:0]        r;
    logic [27:0]        xb;
    logic [7:0]         s;
    logic [9:0]         t;
    logic [16:0]        xc;
    logic [5:0]         u;
  } pipe_t;

  pipe_t stg1, stg1_next, stg2, stg2_next, stg3, stg3_next, stg4, stg4_next;
  pipe_t stg5, stg5_next, stg6, stg6_next, stg7, stg7_next, stg8, stg8_next;
  pipe_t stg9, stg9_next, stg10, stg10_next, stg11, stg11_next;
  jdc_out_t fin, fin_next, dl1, dl2;
  logic [LAT-1:0] vld;
  logic leap;
  logic [WDAY_W-1:0] wday;

  // the pipeline never stalls
  assign busy = 1'b0;

  // stage 1: range check, march-based year and month, julian offset
  always_comb begin
    logic date_bad;
    logic jd_bad;
    logic [3:0] mshift;
    stg1_next = '0;
    stg1_next.func = req.func;
    stg1_next.yi   = req.year_in;
    stg1_next.mi   = req.month_in;
    stg1_next.di   = req.day_in;
    stg1_next.jd   = req.julian_in;
    date_bad = (req.year_in == '0) || (req.year_in > YEAR_MAX) ||
               (req.month_in == '0) || (req.month_in > MONTH_MAX) ||
               (req.day_in == '0);
    jd_bad = (req.julian_in < JD_MIN) || (req.julian_in > JD_MAX);
    stg1_next.err = (req.func == FUNC_JD_TO_DATE) ? jd_bad : date_bad;
    if (req.month_in <= 4'd2) begin
      stg1_next.a = {1'b0, req.year_in} + 15'(EPOCH_Y - 1);
      mshift = req.month_in + 4'd10;
    end else begin
      stg1_next.a = {1'b0, req.year_in} + 15'(EPOCH_Y);
      mshift = req.month_in - 4'd2;
    end
    stg1_next.mterm = CUM_DAYS[mshift];
    stg1_next.p = req.julian_in + 23'(OFS_JD);
  end

  // stage 2: year days, century estimate, 400-year cycle estimate
  always_comb begin
    logic [25:0] t1_prod;
    logic [21:0] c_prod;
    logic [32:0] q_prod;
    stg2_next = stg1;
    t1_prod = 26'(stg1.a) * 26'(DAYS_4Y);
    stg2_next.t1 = t1_prod[24:2];
    stg2_next.ap = 14'(stg1.a + 15'(CENT));
    c_prod = 22'(stg2_next.ap) * 22'(RCP_100);
    stg2_next.c = c_prod[21:14];
    stg2_next.x = {stg1.p, 2'b00};
    q_prod = 33'(stg2_next.x) * 33'(RCP_400Y);
    stg2_next.q = q_prod[32:25];
  end

  // stage 3: correct both quotients, partial julian sum
  always_comb begin
    logic [14:0] c_rem;
    logic [24:0] q_rem;
    stg3_next = stg2;
    c_rem = {1'b0, stg2.ap} - {7'd0, stg2.c} * 15'(CENT);
    if (c_rem >= 15'(CENT)) begin
      stg3_next.c = stg2.c + 8'd1;
    end
    stg3_next.base = stg2.t1 + 23'(stg2.mterm) + 23'(stg2.di) - 23'(JD_BIAS);
    q_rem = stg2.x - {17'd0, stg2.q} * 25'(DAYS_400Y);
    if (q_rem >= 25'(DAYS_400Y)) begin
      stg3_next.q = stg2.q + 8'd1;
    end
  end

  // stage 4: julian day of a date, day within the 400-year cycle
  always_comb begin
    logic [9:0]  t3;
    logic [25:0] q_days;
    stg4_next = stg3;
    t3 = ({2'd0, stg3.c} * 10'd3) >> 2;
    if (stg3.func == FUNC_DATE_TO_JD) begin
      stg4_next.jd = stg3.base - 23'(t3);
    end
    q_days = {18'd0, stg3.q} * 26'(DAYS_400Y) + 26'd3;
    stg4_next.r = 16'(stg3.p - q_days[24:2]);
  end

  // stage 5: scale for the year-in-cycle division
  always_comb begin
    stg5_next = stg4;
    stg5_next.xb = ({12'd0, stg4.r} + 28'd1) * 28'(YEAR_SCALE);
  end

  // stage 6: year-in-cycle estimate
  always_comb begin
    logic [35:0] s_prod;
    stg6_next = stg5;
    s_prod = {8'd0, stg5.xb} * 36'(RCP_4000Y);
    stg6_next.s = s_prod[35:28];
  end

  // stage 7: year-in-cycle correction
  always_comb begin
    logic [27:0] s_rem;
    stg7_next = stg6;
    s_rem = stg6.xb - {20'd0, stg6.s} * 28'(DAYS_4000Y);
    if (s_rem >= 28'(DAYS_4000Y)) begin
      stg7_next.s = stg6.s + 8'd1;
    end
  end

  // stage 8: day within the march-based year
  always_comb begin
    logic [18:0] s_days;
    stg8_next = stg7;
    s_days = {11'd0, stg7.s} * 19'(DAYS_4Y);
    stg8_next.t = 10'(stg7.r - s_days[17:2] + 16'(MONTH_BIAS));
  end

  // stage 9: scale for the month division
  always_comb begin
    stg9_next = stg8;
    stg9_next.xc = {7'd0, stg8.t} * 17'(MONTH_SCALE);
  end

  // stage 10: month estimate
  always_comb begin
    logic [22:0] u_prod;
    stg10_next = stg9;
    u_prod = {6'd0, stg9.xc} * 23'(RCP_MONTH);
    stg10_next.u = u_prod[22:17];
  end

  // stage 11: month correction
  always_comb begin
    logic [16:0] u_rem;
    stg11_next = stg10;
    u_rem = stg10.xc - {11'd0, stg10.u} * 17'(MONTH_DIV);
    if (u_rem >= 17'(MONTH_DIV)) begin
      stg11_next.u = stg10.u + 6'd1;
    end
  end

  // stage 12: assemble year, month, day and select by direction
  always_comb begin
    logic               v;
    logic [YEAR_W-1:0]  yo;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   dd;
    v  = (stg11.u[3:0] >= 4'd11);
    yo = 14'(({6'd0, stg11.q} - 14'd49) * 14'd100) + 14'(stg11.s) + 14'(v);
    mo = stg11.u[3:0] + 4'd2 - (v ? 4'd12 : 4'd0);
    dd = 5'(stg11.t - 10'(CUM_DAYS[stg11.u[3:0]]));
    fin_next = '0;
    if (!stg11.err) begin
      fin_next.julian_out = stg11.jd;
      if (stg11.func == FUNC_JD_TO_DATE) begin
        fin_next.year_out  = yo;
        fin_next.month_out = mo;
        fin_next.day_out   = dd;
      end else begin
        fin_next.year_out  = stg11.yi;
        fin_next.month_out = stg11.mi;
        fin_next.day_out   = stg11.di;
      end
    end
    fin_next.range_error = stg11.err;
  end

  // payload registers
  always_ff @(posedge clk) begin
    stg1  <= stg1_next;
    stg2  <= stg2_next;
    stg3  <= stg3_next;
    stg4  <= stg4_next;
    stg5  <= stg5_next;
    stg6  <= stg6_next;
    stg7  <= stg7_next;
    stg8  <= stg8_next;
    stg9  <= stg9_next;
    stg10 <= stg10_next;
    stg11 <= stg11_next;
    fin   <= fin_next;
    dl1   <= fin;
    dl2   <= dl1;
  end

  // valid bits travel with each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  // weekday and leap flag, registered alongside dl1 and dl2
  jdc_flags u_flags (
    .clk     (clk),
    .year    (fin.year_out),
    .julian  (fin.julian_out),
    .leap    (leap),
    .weekday (wday)
  );

  // result, flags forced to zero on a range error
  always_comb begin
    rsp = dl2;
    rsp.weekday   = dl2.range_error ? '0 : wday;
    rsp.leap_year = leap & ~dl2.range_error;
  end

  assign done = vld[LAT-1];

endmodule

// ----- hw/rtl/jdc_flags.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdc_flags: leap-year flag and weekday of a converted date
// Two register stages: the year is split by 100 through a reciprocal
// estimate and a correction, the weekday is (julian + 1) mod 7 by octal
// digit folding.
// ----------------------------------------------------------------------------
module jdc_flags (
  input  logic                         clk,
  input  logic [jdc_pkg::YEAR_W-1:0]   year,
  input  logic [jdc_pkg::JD_W-1:0]     julian,
  output logic                         leap,
  output logic [jdc_pkg::WDAY_W-1:0]   weekday
);
  import jdc_pkg::*;

  localparam int DIGITS = (JD_W + 1) / 3;

  logic [YEAR_W-1:0] yr;
  logic [7:0]        cent;
  logic [7:0]        cent_next;
  logic [5:0]        dsum;
  logic [5:0]        dsum_next;
  logic              leap_next;
  logic [WDAY_W-1:0] weekday_next;

  // first stage: century estimate and octal digit sum of julian + 1
  always_comb begin
    logic [21:0] cent_prod;
    logic [JD_W:0] jp1;
    cent_prod = 22'(year) * 22'(RCP_100);
    cent_next = cent_prod[21:14];
    jp1 = {1'b0, julian} + (JD_W+1)'(1);
    dsum_next = '0;
    for (int i = 0; i < DIGITS; i++) begin
      dsum_next = dsum_next + 6'(jp1[3*i +: 3]);
    end
  end

  always_ff @(posedge clk) begin
    yr   <= year;
    cent <= cent_next;
    dsum <= dsum_next;
  end

  // second stage: correct the century, leap rule, fold digit sum mod 7
  always_comb begin
    logic [YEAR_W-1:0] rem;
    logic [7:0]        cq;
    logic [3:0]        f1;
    logic [2:0]        f2;
    rem = yr - {6'd0, cent} * 14'(CENT);
    cq  = cent;
    if (rem >= 14'(CENT)) begin
      rem = rem - 14'(CENT);
      cq  = cent + 8'd1;
    end
    leap_next = (yr[1:0] == 2'd0) && ((rem != '0) || (cq[1:0] == 2'd0));
    f1 = 4'(dsum[5:3]) + 4'(dsum[2:0]);
    f2 = 3'(f1[3]) + f1[2:0];
    weekday_next = (f2 == 3'd7) ? 3'd0 : f2;
  end

  always_ff @(posedge clk) begin
    leap    <= leap_next;
    weekday <= weekday_next;
  end

endmodule
